>>> rtl/core/iqv_pkg.sv
// shared types and constants for the interrupt queue vectoring block
package iqv_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CodeW = 8;
  localparam int unsigned CntOutW = 6;
  localparam int unsigned CfgIdxW = 2;
  // vector words are eight bytes apart
  localparam int unsigned VecShift = 3;

  typedef enum logic [1:0] {
    OP_RAISE  = 2'd0,
    OP_RETURN = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_REPLY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_ACCESS     = 3'd1,
    RS_PERMISSION = 3'd2,
    RS_BOUNDS     = 3'd3,
    RS_UNALIGNED  = 3'd4
  } reply_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VECTOR_BASE = 2'd0,
    CFG_ACCESS_CODE = 2'd1,
    CFG_ALIGN_CODE  = 2'd2,
    CFG_OVF_CODE    = 2'd3
  } cfg_idx_e;

  localparam logic [WordW-1:0] VectorBaseRst = '0;
  localparam logic [CodeW-1:0] AccessCodeRst = 8'd1;
  localparam logic [CodeW-1:0] AlignCodeRst  = 8'd2;
  localparam logic [CodeW-1:0] OvfCodeRst    = 8'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [CodeW-1:0] irq_code;
    logic [WordW-1:0] cpu_ip;
    logic [WordW-1:0] cpu_status;
    logic [2:0]       reply_status;
    logic [WordW-1:0] reply_data;
  } in_item_t;

  typedef struct packed {
    logic               rejected;
    logic               ip_write;
    logic [WordW-1:0]   ip_value;
    logic               status_write;
    logic [WordW-1:0]   status_value;
    logic               enter_kernel;
    logic               fetch_valid;
    logic [WordW-1:0]   fetch_address;
    logic [CntOutW-1:0] pending_count;
  } out_item_t;

  typedef struct packed {
    logic [WordW-1:0] vector_table_base;
    logic [CodeW-1:0] access_fault_code;
    logic [CodeW-1:0] alignment_fault_code;
    logic [CodeW-1:0] overflow_code;
  } cfg_t;

endpackage

>>> rtl/core/iqv_if.sv
// valid/ready channel interfaces for input items and result items
interface iqv_in_if;
  import iqv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iqv_out_if;
  import iqv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/interrupt_queue_vectoring.sv
// interrupt queue vectoring top level: config, decision logic, result register
// latency: a result is registered at its input transfer and presented in the following cycle
// throughput: one item per cycle, limited only by the result register handshake
// the single-entry result register lets a new item in whenever it is empty or drained
// reset (rst_ni low, async): queue empty, no fetch outstanding, saved state zero,
// config registers at their defaults, no result pending
module interrupt_queue_vectoring #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [iqv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [iqv_pkg::WordW-1:0]   cfg_wdata_i,
  iqv_in_if.sink                      in_i,
  iqv_out_if.source                   out_o
);
  import iqv_pkg::*;

  cfg_t      cfg;
  out_item_t res;
  out_item_t res_q;
  logic      res_valid_q;
  logic      in_fire;

  iqv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input is taken whenever the result register is free or being drained
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // all state for one item updates at its input transfer, so the next
  // item sees it in the following cycle
  iqv_step #(
    .RING_DEPTH (RING_DEPTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_i.data),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register: valid is control, payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_fire) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

endmodule

>>> rtl/core/iqv_cfg.sv
// configuration register file
module iqv_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iqv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iqv_pkg::WordW-1:0]     cfg_wdata_i,
  output iqv_pkg::cfg_t                 cfg_o
);
  import iqv_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VECTOR_BASE: cfg_d.vector_table_base = cfg_wdata_i;
        CFG_ACCESS_CODE: cfg_d.access_fault_code = cfg_wdata_i[CodeW-1:0];
        CFG_ALIGN_CODE:  cfg_d.alignment_fault_code = cfg_wdata_i[CodeW-1:0];
        CFG_OVF_CODE:    cfg_d.overflow_code = cfg_wdata_i[CodeW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vector_table_base    <= VectorBaseRst;
      cfg_q.access_fault_code    <= AccessCodeRst;
      cfg_q.alignment_fault_code <= AlignCodeRst;
      cfg_q.overflow_code        <= OvfCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/iqv_step.sv
// queue state and per-item decision logic
module iqv_step #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  iqv_pkg::in_item_t    item_i,
  input  iqv_pkg::cfg_t        cfg_i,
  output iqv_pkg::out_item_t   res_o
);
  import iqv_pkg::*;

  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(RING_DEPTH);

  // the ring is only ever read at its newest entry, which is always the
  // code most recently enqueued, so that entry is kept in a register
  logic [CntW-1:0]  count_q, count_d;
  logic [CodeW-1:0] newest_q, newest_d;
  logic [WordW-1:0] saved_ip_q, saved_ip_d;
  logic [WordW-1:0] saved_st_q, saved_st_d;
  logic             fetch_out_q, fetch_out_d;
  logic             fetch_enq_q, fetch_enq_d;
  logic [CodeW-1:0] held_q, held_d;

  logic [CntW-1:0]    cnt_pop;
  logic [CodeW-1:0]   raise_code;
  logic [CodeW-1:0]   fault_code;
  logic [CodeW-1:0]   fetch_code;
  logic               do_raise;
  logic               do_fetch;
  logic [CntW+CntOutW-1:0] cnt_ext;

  assign cnt_pop = count_q - CntW'(1);
  assign fault_code = (item_i.reply_status == RS_UNALIGNED) ? cfg_i.alignment_fault_code
                                                            : cfg_i.access_fault_code;

  always_comb begin
    count_d     = count_q;
    newest_d    = newest_q;
    saved_ip_d  = saved_ip_q;
    saved_st_d  = saved_st_q;
    fetch_out_d = fetch_out_q;
    fetch_enq_d = fetch_enq_q;
    held_d      = held_q;
    res_o       = '0;
    do_raise    = 1'b0;
    do_fetch    = 1'b0;
    raise_code  = item_i.irq_code;
    fetch_code  = newest_q;

    if ((item_i.op == OP_REPLY) != fetch_out_q) begin
      res_o.rejected = 1'b1;
    end else begin
      case (op_e'(item_i.op))
        OP_RAISE: begin
          do_raise = 1'b1;
        end
        OP_RETURN: begin
          if (count_q != '0) begin
            count_d = cnt_pop;
            if (cnt_pop == '0) begin
              res_o.ip_write     = 1'b1;
              res_o.ip_value     = saved_ip_q;
              res_o.status_write = 1'b1;
              res_o.status_value = saved_st_q;
            end else begin
              do_fetch = 1'b1;
            end
          end
        end
        OP_RESOLVE: begin
          if (count_q != '0) begin
            count_d    = cnt_pop;
            saved_ip_d = item_i.cpu_ip;
            saved_st_d = item_i.cpu_status;
            do_fetch   = (cnt_pop != '0);
          end
        end
        OP_REPLY: begin
          fetch_out_d = 1'b0;
          if (item_i.reply_status == RS_OK) begin
            res_o.ip_write = 1'b1;
            res_o.ip_value = item_i.reply_data;
            if (fetch_enq_q && (count_q < Depth)) begin
              newest_d = held_q;
              count_d  = count_q + CntW'(1);
            end
          end else begin
            do_raise   = 1'b1;
            raise_code = fault_code;
          end
        end
        default: res_o.rejected = 1'b1;
      endcase
    end

    // raise path: save on empty ring, clear and substitute on full ring
    if (do_raise) begin
      fetch_code = raise_code;
      if (count_q == '0) begin
        saved_ip_d         = item_i.cpu_ip;
        saved_st_d         = item_i.cpu_status;
        res_o.enter_kernel = 1'b1;
      end
      if (count_q >= Depth) begin
        count_d    = '0;
        fetch_code = cfg_i.overflow_code;
      end
    end

    if (do_raise || do_fetch) begin
      res_o.fetch_valid   = 1'b1;
      res_o.fetch_address = cfg_i.vector_table_base +
                            {{(WordW-CodeW-VecShift){1'b0}}, fetch_code, {VecShift{1'b0}}};
      fetch_out_d = 1'b1;
      fetch_enq_d = do_raise;
      held_d      = fetch_code;
    end

    cnt_ext = {{CntOutW{1'b0}}, count_d};
    res_o.pending_count = cnt_ext[CntOutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      newest_q    <= '0;
      saved_ip_q  <= '0;
      saved_st_q  <= '0;
      fetch_out_q <= 1'b0;
      fetch_enq_q <= 1'b0;
      held_q      <= '0;
    end else if (fire_i) begin
      count_q     <= count_d;
      newest_q    <= newest_d;
      saved_ip_q  <= saved_ip_d;
      saved_st_q  <= saved_st_d;
      fetch_out_q <= fetch_out_d;
      fetch_enq_q <= fetch_enq_d;
      held_q      <= held_d;
    end
  end

endmodule
